@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// Substitution score accumulator package
// Shared constants, codes and payload types.
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam int SSA_PROFILE_DEPTH = 64;
	localparam int SSA_ALPHABET_SIZE = 32;
	localparam int SSA_LETTER_W      = 5;
	localparam int SSA_SCORE_W       = 16;
	// widest per-pair value: sum of two 17-bit differences
	localparam int SSA_VAL_W         = 18;

	localparam logic [6:0]         SSA_POS_MAX = 7'd127;
	localparam logic signed [31:0] SSA_SUM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SSA_SUM_MIN = 32'sh8000_0000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCORE = 1'b1;

	typedef enum logic [1:0] {
		CONV_RAW   = 2'd0,
		CONV_QUASI = 2'd1,
		CONV_MAX   = 2'd2,
		CONV_AVG   = 2'd3
	} ssa_conv_t;

	typedef enum logic [2:0] {
		REG_PROFILE_MODE    = 3'd0,
		REG_CONVERSION_MODE = 3'd1,
		REG_ALPHABET_MASK   = 3'd2,
		REG_PROFILE_LENGTH  = 3'd3,
		REG_LARGE_DISTANCE  = 3'd4
	} ssa_reg_t;

	typedef struct packed {
		logic               op;
		logic [5:0]         table_row;
		logic [4:0]         table_col;
		logic signed [15:0] table_value;
		logic [7:0]         residue_a;
		logic [7:0]         residue_b;
		logic               last;
	} ssa_item_t;

	typedef struct packed {
		logic signed [31:0] total_score;
		logic               saturated;
	} ssa_result_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] value;
	} ssa_cfg_t;

endpackage

@@ rtl/core/ssa_if.sv @@
// ----------------------------------------------------------------------------
// Substitution score accumulator channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface ssa_req_if;
	logic                valid;
	logic                ready;
	ssa_pkg::ssa_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ssa_rsp_if;
	logic                 valid;
	logic                 ready;
	ssa_pkg::ssa_result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ssa_cfg_if;
	logic              valid;
	logic              ready;
	ssa_pkg::ssa_cfg_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ssa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, read data registered (old data on a
// same-address write).
// ----------------------------------------------------------------------------
module ssa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ rtl/core/substitution_score_accumulator.sv @@
// ----------------------------------------------------------------------------
// Substitution score accumulator: a write item is taken every cycle unless held off.
// A score item holds off the next item while its phase 1 reads are issued, as four
// table reads per pair share the two read ports of the table RAM.
// Reset: registers to defaults, sum/position/clip cleared; table undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

// Datapath overview
//   issue : accept item. Write items go straight into the table RAM.
//           Score items issue two reads (phase 0) at acceptance, and two more
//           (phase 1) in the next cycle from the stage 1 hold registers.
//             phase 0: A = M[k][k] (profile: M[pos][k]), B = M[k][j]
//             phase 1: A = M[j][j],                       B = M[j][k]
//   s2    : capture phase 0 data, form the forward difference.
//   s3    : form the per-pair value from phase 0 and phase 1 data and the mode.
//   acc   : saturating 32-bit add into the running sum; on last, push the
//           total into a four-entry result queue and clear the sequence state.
// Items stay in order, and a later read is always issued after an earlier
// write, so the read-old-data RAM never needs forwarding.
// A result slot is reserved when a last item is accepted, so the queue can
// never overflow while results wait downstream.

module substitution_score_accumulator
	import ssa_pkg::*;
#(
	parameter int PROFILE_DEPTH = SSA_PROFILE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ssa_cfg_if.sink   cfg,
	ssa_req_if.sink   req,
	ssa_rsp_if.source rsp
);

	localparam int TABLE_DEPTH = PROFILE_DEPTH * SSA_ALPHABET_SIZE;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int ROW_W       = ADDR_W - SSA_LETTER_W;
	// a slot is held from acceptance until the result is taken; four slots
	// keep last items flowing at the full score item rate
	localparam int RES_DEPTH   = 4;
	localparam int RES_PTR_W   = $clog2(RES_DEPTH);
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic      profile;
		logic      prof_hit;
		logic      off_alpha;
		ssa_conv_t conv;
		logic      last;
	} score_tag_t;

	// configuration registers
	logic             profile_mode_q;
	ssa_conv_t        conv_mode_q;
	logic [31:0]      alpha_mask_q;
	logic [6:0]       prof_len_q;
	logic [14:0]      large_dist_q;

	// issue
	logic                    req_fire, score_fire, write_fire, row_ok;
	logic [SSA_LETTER_W-1:0] k_in, j_in;
	logic [ADDR_W-1:0]       addr_a, addr_b, waddr;
	logic [SSA_SCORE_W-1:0]  rdata_a, rdata_b;
	logic signed [15:0]      rd_a, rd_b;
	logic [6:0]              pos_q;
	score_tag_t              tag_in;

	// pipeline
	logic                    v_s1, v_s2, v_s3;
	logic [SSA_LETTER_W-1:0] k_s1, j_s1;
	score_tag_t              tag_s1, tag_s2;
	logic signed [16:0]      fwd_s2, rev;
	logic signed [15:0]      rda_s2, rdb_s2;
	logic signed [SSA_VAL_W-1:0] val, val_s3;
	logic                    last_s3;

	// accumulator
	logic signed [31:0] run_q, run_next;
	logic               clip_q, ovf;
	logic [32:0]        sum;

	// result queue
	ssa_result_t          ent_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_CNT_W-1:0] fifo_cnt_q, res_cnt_q;
	logic                 push, pop, reserve;

	// ------------------------------------------------------------------
	// Configuration port: always ready, writes take effect in the next cycle
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_mode_q <= 1'b0;
			conv_mode_q    <= CONV_RAW;
			alpha_mask_q   <= '1;
			prof_len_q     <= '0;
			large_dist_q   <= '1;
		end else if (cfg.valid) begin
			unique case (ssa_reg_t'(cfg.data.index))
				REG_PROFILE_MODE:    profile_mode_q <= cfg.data.value[0];
				REG_CONVERSION_MODE: conv_mode_q    <= ssa_conv_t'(cfg.data.value[1:0]);
				REG_ALPHABET_MASK:   alpha_mask_q   <= cfg.data.value;
				REG_PROFILE_LENGTH:  prof_len_q     <= cfg.data.value[6:0];
				REG_LARGE_DISTANCE:  large_dist_q   <= cfg.data.value[14:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Issue: hold off while phase 1 reads are pending or every result
	// slot is reserved
	// ------------------------------------------------------------------
	assign req.ready  = !v_s1 && (res_cnt_q != RES_CNT_W'(RES_DEPTH));
	assign req_fire   = req.valid && req.ready;
	assign score_fire = req_fire && (req.data.op == OP_SCORE);
	assign write_fire = req_fire && (req.data.op == OP_WRITE);
	// rows past the profile depth are dropped
	assign row_ok     = 32'(req.data.table_row) < PROFILE_DEPTH;
	assign waddr      = {ROW_W'(req.data.table_row), req.data.table_col};

	assign k_in = req.data.residue_a[SSA_LETTER_W-1:0];
	assign j_in = req.data.residue_b[SSA_LETTER_W-1:0];

	always_comb begin
		tag_in.profile   = profile_mode_q;
		tag_in.prof_hit  = (pos_q < prof_len_q) && (32'(pos_q) < PROFILE_DEPTH);
		// raw mode does not check the alphabet
		tag_in.off_alpha = (conv_mode_q != CONV_RAW) &&
		                   (!alpha_mask_q[k_in] || !alpha_mask_q[j_in]);
		tag_in.conv      = conv_mode_q;
		tag_in.last      = req.data.last;
	end

	always_comb begin
		if (v_s1) begin
			addr_a = {ROW_W'(j_s1), j_s1};
			addr_b = {ROW_W'(j_s1), k_s1};
		end else if (profile_mode_q) begin
			addr_a = {ROW_W'(pos_q), k_in};
			addr_b = {ROW_W'(k_in), j_in};
		end else begin
			addr_a = {ROW_W'(k_in), k_in};
			addr_b = {ROW_W'(k_in), j_in};
		end
	end

	ssa_ram #(
		.WIDTH (SSA_SCORE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (write_fire && row_ok),
		.waddr   (waddr),
		.wdata   (req.data.table_value),
		.raddr_a (addr_a),
		.rdata_a (rdata_a),
		.raddr_b (addr_b),
		.rdata_b (rdata_b)
	);

	assign rd_a = rdata_a;
	assign rd_b = rdata_b;

	// profile column counter: advance in profile mode, saturate, clear on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (score_fire) begin
			if (req.data.last) begin
				pos_q <= '0;
			end else if (profile_mode_q && (pos_q != SSA_POS_MAX)) begin
				pos_q <= pos_q + 7'd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline valids
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= score_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ------------------------------------------------------------------
	// Payload stages
	// ------------------------------------------------------------------
	assign rev = 17'(rd_a) - 17'(rd_b);

	// per-pair value from phase 0 (s2 registers) and phase 1 (RAM output)
	always_comb begin
		if (tag_s2.profile) begin
			val = tag_s2.prof_hit ? SSA_VAL_W'(rda_s2) : '0;
		end else if (tag_s2.conv == CONV_RAW) begin
			val = SSA_VAL_W'(rdb_s2);
		end else if (tag_s2.off_alpha) begin
			val = SSA_VAL_W'(large_dist_q);
		end else begin
			case (tag_s2.conv)
				CONV_QUASI: val = SSA_VAL_W'(fwd_s2);
				CONV_MAX:   val = (fwd_s2 > rev) ? SSA_VAL_W'(fwd_s2) : SSA_VAL_W'(rev);
				default:    val = SSA_VAL_W'(fwd_s2) + SSA_VAL_W'(rev);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (score_fire) begin
			k_s1   <= k_in;
			j_s1   <= j_in;
			tag_s1 <= tag_in;
		end
		if (v_s1) begin
			rda_s2 <= rd_a;
			rdb_s2 <= rd_b;
			fwd_s2 <= 17'(rd_a) - 17'(rd_b);
			tag_s2 <= tag_s1;
		end
		if (v_s2) begin
			val_s3  <= val;
			last_s3 <= tag_s2.last;
		end
	end

	// ------------------------------------------------------------------
	// Accumulator: saturate at the signed 32-bit range
	// ------------------------------------------------------------------
	assign sum      = {run_q[31], run_q} + 33'(val_s3);
	assign ovf      = sum[32] != sum[31];
	assign run_next = ovf ? (sum[32] ? SSA_SUM_MIN : SSA_SUM_MAX) : sum[31:0];
	assign push     = v_s3 && last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			clip_q <= 1'b0;
		end else if (v_s3) begin
			if (last_s3) begin
				run_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				run_q  <= run_next;
				clip_q <= clip_q || ovf;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue: four entries, slot reserved when a last item enters
	// ------------------------------------------------------------------
	assign pop       = rsp.valid && rsp.ready;
	assign reserve   = score_fire && req.data.last;
	assign rsp.valid = fifo_cnt_q != '0;
	assign rsp.data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{total_score: run_next, saturated: clip_q || ovf};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + RES_CNT_W'(1);
			end else if (pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - RES_CNT_W'(1);
			end
			if (reserve && !pop) begin
				res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
			end else if (pop && !reserve) begin
				res_cnt_q <= res_cnt_q - RES_CNT_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_ALWAYS(a_res_cnt_bound, res_cnt_q <= RES_CNT_W'(RES_DEPTH), "result reservations exceed queue depth")
	`ASSERT_ALWAYS(a_queue_reserved, fifo_cnt_q <= res_cnt_q, "queued results exceed reservations")
	`ASSERT_IMPLIES(a_push_room, push, fifo_cnt_q != RES_CNT_W'(RES_DEPTH), "result pushed into a full queue")
	`ASSERT_NEXT(a_pair_spacing, v_s2, !v_s2, "score items closer than two cycles")

endmodule
